// File: design/trnp_pkg.sv
// Shared constants and controller/datapath interface types for the radix number parser.
package trnp_pkg;

  // Word buffer geometry
  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_OUT_W    = 6;
  localparam int CHAR_W       = 8;
  localparam int RADIX_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int VALUE_W      = 16;
  localparam int MAG_W        = 16;

  localparam logic [ADDR_W-1:0] FILL_MAX = ADDR_W'(BUFFER_DEPTH - 1);

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VTAB      = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_RUBOUT    = 8'h7F;

  // Printable characters used by the parser
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // Radix codes
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_2    = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_8    = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_10   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_16   = 5'd16;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NOT_NUMBER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IN_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 2'd2;

  localparam logic [MAG_W-1:0]   VALUE_LIMIT = 16'h7FFF;
  localparam logic [MAG_W-1:0]   MAG_SAT     = 16'h8000;
  localparam logic [VALUE_W-1:0] VALUE_OUT   = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic store;  // take an ordinary or erase character
    logic start;  // take a delimiter, begin the buffer walk
    logic step;   // advance the buffer walk
    logic load;   // move the finished result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic delim;      // current input character ends a word
    logic walk_done;  // every buffered character has been parsed
  } dp_status_t;

endpackage

// File: design/token_reader_radix_number_parser.sv
// Top level of the typed-word radix number parser.
// Characters arrive one per request and are gathered into a word of up to BUFFER_DEPTH-1
// characters; backspace and rubout drop the last one, extra characters are discarded.
// An ordinary character or an erase is taken without a buffer walk. A space or newline ends the
// word: the block then reads the word buffer back one character per cycle through its
// registered read port and parses it digit by digit; the result is loaded into the
// output register when the walk is done and any previous result there has been taken.
// While a word is parsed no request is taken. The result stays on the output until
// taken; characters are taken meanwhile. The radix register is written with cfg_write
// and cfg_data.
module token_reader_radix_number_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [trnp_pkg::RADIX_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [trnp_pkg::CHAR_W-1:0]         character,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [trnp_pkg::STATUS_W-1:0]       status,
  output logic signed [trnp_pkg::VALUE_W-1:0] value,
  output logic                                line_end,
  output logic [trnp_pkg::LEN_OUT_W-1:0]      word_length
);

  trnp_pkg::cmd_t       cmd;
  trnp_pkg::dp_status_t dp_stat;

  // Sequencer
  trnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // Buffer and parser
  trnp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .character   (character),
    .cmd         (cmd),
    .dp_stat     (dp_stat),
    .status      (status),
    .value       (value),
    .line_end    (line_end),
    .word_length (word_length)
  );

endmodule

// File: design/trnp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module trnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/trnp_ctrl.sv
// Controller state machine: character intake, buffer walk sequencing and output handshake.
module trnp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  trnp_pkg::dp_status_t  dp_stat,
  output trnp_pkg::cmd_t        cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode commands from state and handshakes
  always_comb begin
    cmd.store = (state == S_IDLE) && in_valid && !dp_stat.delim;
    cmd.start = (state == S_IDLE) && in_valid && dp_stat.delim;
    cmd.step  = (state == S_WALK);
    cmd.load  = (state == S_WALK) && dp_stat.walk_done && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.start) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (cmd.load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold a result until the consumer takes it
  always_comb begin
    priority if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: design/trnp_dp.sv
// Datapath: word buffer, fill count, serial strtol-style digit parser and result register.
module trnp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [trnp_pkg::RADIX_W-1:0]        cfg_data,
  input  logic [trnp_pkg::CHAR_W-1:0]         character,
  input  trnp_pkg::cmd_t                      cmd,
  output trnp_pkg::dp_status_t                dp_stat,
  output logic [trnp_pkg::STATUS_W-1:0]       status,
  output logic signed [trnp_pkg::VALUE_W-1:0] value,
  output logic                                line_end,
  output logic [trnp_pkg::LEN_OUT_W-1:0]      word_length
);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_LEAD  = 3'd0;  // skipping leading blanks
  localparam logic [PH_W-1:0] PH_START = 3'd1;  // sign seen, first digit next
  localparam logic [PH_W-1:0] PH_ZERO  = 3'd2;  // leading zero seen, maybe a prefix
  localparam logic [PH_W-1:0] PH_X     = 3'd3;  // zero and x seen, prefix pending
  localparam logic [PH_W-1:0] PH_DIG   = 3'd4;  // in the digit run

  localparam int DIG_W = 6;
  localparam logic [DIG_W-1:0] NO_DIGIT = 6'd63;
  localparam logic [DIG_W-1:0] DIG_HEX  = 6'd16;
  localparam logic [DIG_W-1:0] DIG_TEN  = 6'd10;
  localparam int MAC_W = trnp_pkg::MAG_W + trnp_pkg::RADIX_W;

  function automatic logic [DIG_W-1:0] digit_of(input logic [trnp_pkg::CHAR_W-1:0] ch);
    logic [DIG_W-1:0] d;
    if (ch >= trnp_pkg::CH_ZERO && ch <= trnp_pkg::CH_NINE) begin
      d = DIG_W'(ch - trnp_pkg::CH_ZERO);
    end else if (ch >= trnp_pkg::CH_LA && ch <= trnp_pkg::CH_LZ) begin
      d = DIG_W'(ch - trnp_pkg::CH_LA) + DIG_TEN;
    end else if (ch >= trnp_pkg::CH_UA && ch <= trnp_pkg::CH_UZ) begin
      d = DIG_W'(ch - trnp_pkg::CH_UA) + DIG_TEN;
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [trnp_pkg::CHAR_W-1:0] ch);
    return ch == trnp_pkg::CH_TAB || ch == trnp_pkg::CH_VTAB ||
           ch == trnp_pkg::CH_FORMFEED || ch == trnp_pkg::CH_RETURN ||
           ch == trnp_pkg::CH_SPACE || ch == trnp_pkg::CH_NEWLINE;
  endfunction

  logic [trnp_pkg::RADIX_W-1:0] radix_mode;
  logic [trnp_pkg::ADDR_W-1:0]  fill;
  logic [trnp_pkg::ADDR_W-1:0]  len;
  logic [trnp_pkg::ADDR_W-1:0]  idx;
  logic                         pending;
  logic                         is_erase;
  logic                         ram_we;
  logic [trnp_pkg::CHAR_W-1:0]  c;

  logic [PH_W-1:0]              phase, phase_next;
  logic                         fail, fail_next;
  logic                         neg, neg_next;
  logic [trnp_pkg::MAG_W-1:0]   mag, mag_next;
  logic [trnp_pkg::RADIX_W-1:0] base, base_next;
  logic                         line_end_q;
  logic [trnp_pkg::RADIX_W-1:0] start_base;

  logic [DIG_W-1:0]             d;
  logic                         first_digit;
  logic [trnp_pkg::RADIX_W-1:0] b_first;
  logic [MAC_W-1:0]             mac;
  logic                         base_open;

  logic [trnp_pkg::STATUS_W-1:0] res_status;
  logic [trnp_pkg::VALUE_W-1:0]  res_value;
  logic [trnp_pkg::ADDR_W+trnp_pkg::LEN_OUT_W-1:0] len_ext;

  // Classify the incoming character
  assign dp_stat.delim = (character == trnp_pkg::CH_NEWLINE) ||
                         (character == trnp_pkg::CH_SPACE);
  assign is_erase = (character == trnp_pkg::CH_BACKSPACE) ||
                    (character == trnp_pkg::CH_RUBOUT);
  assign ram_we   = cmd.store && !is_erase && (fill != trnp_pkg::FILL_MAX);

  // Word buffer
  trnp_ram #(
    .WIDTH(trnp_pkg::CHAR_W),
    .DEPTH(trnp_pkg::BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill),
    .wdata (character),
    .raddr (idx),
    .rdata (c)
  );

  assign dp_stat.walk_done = (idx == len) && !pending;

  // Resolve the configured radix; unsupported values fall back to auto
  always_comb begin
    if (radix_mode == trnp_pkg::RADIX_2 || radix_mode == trnp_pkg::RADIX_8 ||
        radix_mode == trnp_pkg::RADIX_10 || radix_mode == trnp_pkg::RADIX_16) begin
      start_base = radix_mode;
    end else begin
      start_base = trnp_pkg::RADIX_AUTO;
    end
  end

  assign d         = digit_of(c);
  assign base_open = (base == trnp_pkg::RADIX_16) || (base == trnp_pkg::RADIX_AUTO);
  assign b_first   = (base == trnp_pkg::RADIX_AUTO) ? trnp_pkg::RADIX_10 : base;

  // Accumulate one digit, saturating just above the limit
  always_comb begin
    mac = MAC_W'(mag) * MAC_W'(base) + MAC_W'(d);
    if (mac > MAC_W'(trnp_pkg::MAG_SAT)) begin
      mac = MAC_W'(trnp_pkg::MAG_SAT);
    end
  end

  // Parse the character read in the previous cycle
  always_comb begin
    phase_next  = phase;
    fail_next   = fail;
    neg_next    = neg;
    mag_next    = mag;
    base_next   = base;
    first_digit = 1'b0;
    if (pending && !fail) begin
      unique case (phase)
        PH_LEAD: begin
          if (is_blank(c)) begin
            phase_next = PH_LEAD;
          end else if (c == trnp_pkg::CH_PLUS || c == trnp_pkg::CH_MINUS) begin
            neg_next   = (c == trnp_pkg::CH_MINUS);
            phase_next = PH_START;
          end else begin
            first_digit = 1'b1;
          end
        end
        PH_START: begin
          first_digit = 1'b1;
        end
        PH_ZERO: begin
          if (base_open && (c == trnp_pkg::CH_LX || c == trnp_pkg::CH_UX)) begin
            phase_next = PH_X;
          end else begin
            // plain leading zero: auto radix means octal
            if (base == trnp_pkg::RADIX_AUTO) begin
              base_next = trnp_pkg::RADIX_8;
            end
            if (d >= DIG_W'((base == trnp_pkg::RADIX_AUTO) ? trnp_pkg::RADIX_8 : base)) begin
              fail_next = 1'b1;
            end else begin
              mag_next = trnp_pkg::MAG_W'(d);
            end
            phase_next = PH_DIG;
          end
        end
        PH_X: begin
          // the prefix must be followed by a hex digit, else the word fails
          if (d < DIG_HEX) begin
            base_next  = trnp_pkg::RADIX_16;
            mag_next   = trnp_pkg::MAG_W'(d);
            phase_next = PH_DIG;
          end else begin
            fail_next = 1'b1;
          end
        end
        PH_DIG: begin
          if (d >= DIG_W'(base)) begin
            fail_next = 1'b1;
          end else begin
            mag_next = mac[trnp_pkg::MAG_W-1:0];
          end
        end
        default: fail_next = 1'b1;
      endcase
      if (first_digit) begin
        if (c == trnp_pkg::CH_ZERO && base_open) begin
          phase_next = PH_ZERO;
        end else begin
          base_next  = b_first;
          phase_next = PH_DIG;
          if (d >= DIG_W'(b_first)) begin
            fail_next = 1'b1;
          end else begin
            mag_next = trnp_pkg::MAG_W'(d);
          end
        end
      end
    end
  end

  // Form the result from the final parse state
  always_comb begin
    if (fail || !(phase == PH_ZERO || phase == PH_DIG)) begin
      res_status = trnp_pkg::ST_NOT_NUMBER;
      res_value  = '0;
    end else if ((neg && mag != '0) || mag > trnp_pkg::VALUE_LIMIT) begin
      res_status = trnp_pkg::ST_OUT_RANGE;
      res_value  = trnp_pkg::VALUE_OUT;
    end else begin
      res_status = trnp_pkg::ST_IN_RANGE;
      res_value  = trnp_pkg::VALUE_W'(mag);
    end
  end

  // Control state: radix register, fill count, read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= trnp_pkg::RADIX_AUTO;
      fill       <= '0;
      pending    <= 1'b0;
    end else begin
      if (cfg_write) begin
        radix_mode <= cfg_data;
      end
      if (cmd.start) begin
        fill <= '0;
      end else if (cmd.store) begin
        if (is_erase) begin
          if (fill != '0) begin
            fill <= fill - 1'b1;
          end
        end else if (fill != trnp_pkg::FILL_MAX) begin
          fill <= fill + 1'b1;
        end
      end
      pending <= cmd.step && (idx != len);
    end
  end

  // Walk registers and parse state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len        <= fill;
      idx        <= '0;
      line_end_q <= (character == trnp_pkg::CH_NEWLINE);
      phase      <= PH_LEAD;
      fail       <= 1'b0;
      neg        <= 1'b0;
      mag        <= '0;
      base       <= start_base;
    end else begin
      if (cmd.step && idx != len) begin
        idx <= idx + 1'b1;
      end
      phase <= phase_next;
      fail  <= fail_next;
      neg   <= neg_next;
      mag   <= mag_next;
      base  <= base_next;
    end
  end

  assign len_ext = {{trnp_pkg::LEN_OUT_W{1'b0}}, len};

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= res_status;
      value       <= res_value;
      line_end    <= line_end_q;
      word_length <= len_ext[trnp_pkg::LEN_OUT_W-1:0];
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the radix number parser: predicts each word result and compares it.
module tb;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int PARSE_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int NO_DIGIT     = 99;
  localparam int PHASE_CHARS  = 115;

  // Radix values that the block does not support: all fall back to auto-detect
  localparam logic [trnp_pkg::RADIX_W-1:0] RADIX_UNUSED_LO  = 5'd1;
  localparam logic [trnp_pkg::RADIX_W-1:0] RADIX_UNUSED_MID = 5'd17;
  localparam logic [trnp_pkg::RADIX_W-1:0] RADIX_UNUSED_HI  = 5'd31;

  typedef struct packed {
    logic [trnp_pkg::STATUS_W-1:0]       status;
    logic signed [trnp_pkg::VALUE_W-1:0] value;
    logic                                line_end;
    logic [trnp_pkg::LEN_OUT_W-1:0]      word_length;
  } word_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [trnp_pkg::RADIX_W-1:0]        cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [trnp_pkg::CHAR_W-1:0]         character = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [trnp_pkg::STATUS_W-1:0]       status;
  logic signed [trnp_pkg::VALUE_W-1:0] value;
  logic                                line_end;
  logic [trnp_pkg::LEN_OUT_W-1:0]      word_length;

  // Predicted state of the word gatherer
  logic [trnp_pkg::CHAR_W-1:0]  word_chars [trnp_pkg::BUFFER_DEPTH];
  int                           word_fill = 0;
  logic [trnp_pkg::RADIX_W-1:0] radix_reg = trnp_pkg::RADIX_AUTO;
  word_result_t                 pending_words [$];

  int          errors = 0;
  int          cycles = 0;
  int          chars_sent = 0;
  int          burst_left = 0;
  int          rx_count = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_stall_on = 1'b0;
  logic [15:0] rx_pattern = 16'hFFFF;

  token_reader_radix_number_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .character   (character),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .value       (value),
    .line_end    (line_end),
    .word_length (word_length)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Digit weight of a character in any base up to 36
  function automatic int digit_of(logic [trnp_pkg::CHAR_W-1:0] c);
    if (c >= trnp_pkg::CH_ZERO && c <= trnp_pkg::CH_NINE) begin
      return int'(c) - int'(trnp_pkg::CH_ZERO);
    end
    if (c >= trnp_pkg::CH_LA && c <= trnp_pkg::CH_LZ) return int'(c) - int'(trnp_pkg::CH_LA) + 10;
    if (c >= trnp_pkg::CH_UA && c <= trnp_pkg::CH_UZ) return int'(c) - int'(trnp_pkg::CH_UA) + 10;
    return NO_DIGIT;
  endfunction

  function automatic bit is_lead_blank(logic [trnp_pkg::CHAR_W-1:0] c);
    return c == trnp_pkg::CH_TAB || c == trnp_pkg::CH_VTAB || c == trnp_pkg::CH_FORMFEED ||
           c == trnp_pkg::CH_RETURN || c == trnp_pkg::CH_SPACE || c == trnp_pkg::CH_NEWLINE;
  endfunction

  // Parse the held word in the current radix
  function automatic word_result_t parse_word(logic ends_line);
    word_result_t res;
    int           pos;
    int           base;
    int           mag;
    int           d;
    logic         neg;
    res.status      = trnp_pkg::ST_NOT_NUMBER;
    res.value       = '0;
    res.line_end    = ends_line;
    res.word_length = trnp_pkg::LEN_OUT_W'(word_fill);
    pos = 0;
    mag = 0;
    neg = 1'b0;
    while (pos < word_fill && is_lead_blank(word_chars[pos])) pos++;
    if (pos < word_fill && (word_chars[pos] == trnp_pkg::CH_PLUS ||
                            word_chars[pos] == trnp_pkg::CH_MINUS)) begin
      neg = (word_chars[pos] == trnp_pkg::CH_MINUS);
      pos++;
    end
    if (radix_reg == trnp_pkg::RADIX_2 || radix_reg == trnp_pkg::RADIX_8 ||
        radix_reg == trnp_pkg::RADIX_10 || radix_reg == trnp_pkg::RADIX_16) begin
      base = int'(radix_reg);
    end else begin
      base = 0;
    end
    // take the hex prefix only when a hex digit follows it
    if ((base == 16 || base == 0) && pos + 2 < word_fill &&
        word_chars[pos] == trnp_pkg::CH_ZERO &&
        (word_chars[pos + 1] == trnp_pkg::CH_LX || word_chars[pos + 1] == trnp_pkg::CH_UX) &&
        digit_of(word_chars[pos + 2]) < 16) begin
      pos += 2;
      base = 16;
    end
    if (base == 0) base = (pos < word_fill && word_chars[pos] == trnp_pkg::CH_ZERO) ? 8 : 10;
    if (pos >= word_fill) return res;
    // accumulate, saturating just past the limit
    while (pos < word_fill) begin
      d = digit_of(word_chars[pos]);
      if (d >= base) return res;
      mag = mag * base + d;
      if (mag > int'(trnp_pkg::MAG_SAT)) mag = int'(trnp_pkg::MAG_SAT);
      pos++;
    end
    if ((neg && mag != 0) || mag > int'(trnp_pkg::VALUE_LIMIT)) begin
      res.status = trnp_pkg::ST_OUT_RANGE;
      res.value  = trnp_pkg::VALUE_OUT;
    end else begin
      res.status = trnp_pkg::ST_IN_RANGE;
      res.value  = trnp_pkg::VALUE_W'(mag);
    end
    return res;
  endfunction

  // Advance the predicted word by one accepted character
  function automatic void predict_char(logic [trnp_pkg::CHAR_W-1:0] c);
    if (c == trnp_pkg::CH_SPACE || c == trnp_pkg::CH_NEWLINE) begin
      pending_words.push_back(parse_word(c == trnp_pkg::CH_NEWLINE));
      word_fill = 0;
    end else if (c == trnp_pkg::CH_BACKSPACE || c == trnp_pkg::CH_RUBOUT) begin
      if (word_fill > 0) word_fill--;
    end else if (word_fill < trnp_pkg::BUFFER_DEPTH - 1) begin
      word_chars[word_fill] = c;
      word_fill++;
    end
  endfunction

  function automatic logic [trnp_pkg::CHAR_W-1:0] digit_char(int d, bit upper);
    if (d < 10) return trnp_pkg::CH_ZERO + trnp_pkg::CHAR_W'(d);
    return (upper ? trnp_pkg::CH_UA : trnp_pkg::CH_LA) + trnp_pkg::CHAR_W'(d - 10);
  endfunction

  function automatic logic [trnp_pkg::CHAR_W-1:0] lead_blank();
    case ($urandom_range(0, 3))
      0: return trnp_pkg::CH_TAB;
      1: return trnp_pkg::CH_VTAB;
      2: return trnp_pkg::CH_FORMFEED;
      default: return trnp_pkg::CH_RETURN;
    endcase
  endfunction

  function automatic int pick_auto_base();
    case ($urandom_range(0, 2))
      0: return 8;
      1: return 10;
      default: return 16;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Send one character request, opening bursts with random gaps when idling is on
  task automatic send_char(input logic [trnp_pkg::CHAR_W-1:0] c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_idle_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    character <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold requests until every result is out and the parser has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (PARSE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [trnp_pkg::RADIX_W-1:0] r);
    cfg_write <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
    radix_reg = r;
  endtask

  // Build one word, mostly a well-formed number in the current radix
  task automatic send_random_word();
    logic [trnp_pkg::CHAR_W-1:0] text [$];
    logic [trnp_pkg::CHAR_W-1:0] digits [$];
    longint unsigned             num;
    int                          base;
    int                          kind;
    int                          spot;
    bit                          upper;
    bit                          fixed;
    fixed = (radix_reg == trnp_pkg::RADIX_2 || radix_reg == trnp_pkg::RADIX_8 ||
             radix_reg == trnp_pkg::RADIX_10 || radix_reg == trnp_pkg::RADIX_16);
    base  = fixed ? int'(radix_reg) : pick_auto_base();
    upper = $urandom_range(0, 1);
    kind  = $urandom_range(0, 99);
    if (kind < 8) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(0, 8)) text.push_back(trnp_pkg::CHAR_W'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      // long digit run: up to 72 digits, so the buffer may fill and drop the tail
      repeat ($urandom_range(50, 72)) begin
        text.push_back(digit_char($urandom_range(0, base - 1), upper));
      end
      if (kind < 10) text.push_back(trnp_pkg::CH_BACKSPACE);
    end else begin
      case ($urandom_range(0, 9))
        0: num = 0;
        1: num = trnp_pkg::VALUE_LIMIT;
        2: num = trnp_pkg::MAG_SAT;
        3: num = 1;
        4, 5, 6: num = $urandom_range(0, 255);
        7: num = $urandom_range(0, 32767);
        8: num = $urandom_range(32700, 32900);
        default: num = $urandom >> $urandom_range(0, 16);
      endcase
      do begin
        digits.push_front(digit_char(int'(num % base), upper));
        num = num / base;
      end while (num != 0);
      if ($urandom_range(0, 9) == 0) text.push_back(lead_blank());
      case ($urandom_range(0, 7))
        0: text.push_back(trnp_pkg::CH_MINUS);
        1: text.push_back(trnp_pkg::CH_PLUS);
        default: ;
      endcase
      if (base == 16 && (!fixed || $urandom_range(0, 1))) begin
        text.push_back(trnp_pkg::CH_ZERO);
        text.push_back(upper ? trnp_pkg::CH_UX : trnp_pkg::CH_LX);
      end else if (base == 8 && !fixed) begin
        text.push_back(trnp_pkg::CH_ZERO);
      end else if (fixed && $urandom_range(0, 4) == 0) begin
        text.push_back(trnp_pkg::CH_ZERO);
      end
      text = {text, digits};
      // break the word with a stray byte
      if ($urandom_range(0, 7) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = trnp_pkg::CHAR_W'($urandom_range(0, 255));
      end
      // typo fixed by an erase
      if ($urandom_range(0, 7) == 0) begin
        spot = $urandom_range(0, text.size());
        text.insert(spot, trnp_pkg::CHAR_W'($urandom_range(0, 255)));
        text.insert(spot + 1, $urandom_range(0, 1) ? trnp_pkg::CH_BACKSPACE : trnp_pkg::CH_RUBOUT);
      end
    end
    foreach (text[i]) send_char(text[i]);
    send_char($urandom_range(0, 1) ? trnp_pkg::CH_NEWLINE : trnp_pkg::CH_SPACE);
  endtask

  // Special words in auto mode straight after reset
  task automatic test_special_words();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b0;
    send_char(trnp_pkg::CH_RUBOUT);
    send_char(trnp_pkg::CH_SPACE);
    send_char(trnp_pkg::CH_NEWLINE);
    send_text("-0\n");
    send_text("0x ");
    send_char(trnp_pkg::CH_TAB);
    send_char(trnp_pkg::CH_VTAB);
    send_text("0x7fFf\n");
    send_char(trnp_pkg::CH_NINE);
    send_char(trnp_pkg::CH_BACKSPACE);
    send_char(8'h00);
    send_char(trnp_pkg::CH_SPACE);
    send_text("-32768\n");
    send_char(8'hFF);
    send_char(trnp_pkg::CH_SPACE);
  endtask

  // Random words under each supported radix, auto and three unsupported settings, with each idling mix
  task automatic test_radix_sweep();
    logic [trnp_pkg::RADIX_W-1:0] radices [8];
    int                           goal;
    radices = '{trnp_pkg::RADIX_16, trnp_pkg::RADIX_2, trnp_pkg::RADIX_8, trnp_pkg::RADIX_10,
                RADIX_UNUSED_HI, RADIX_UNUSED_LO, RADIX_UNUSED_MID, trnp_pkg::RADIX_AUTO};
    foreach (radices[i]) begin
      drain_results();
      write_radix(radices[i]);
      tx_idle_on  = (i % 2 == 1);
      rx_stall_on = ((i / 2) % 2 == 1);
      goal = chars_sent + PHASE_CHARS;
      while (chars_sent < goal) send_random_word();
    end
  endtask

  // Raw bytes with frequent delimiters under full idling
  task automatic test_noise_bytes();
    logic [trnp_pkg::CHAR_W-1:0] ch;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    repeat (150) begin
      ch = trnp_pkg::CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) begin
        ch = $urandom_range(0, 1) ? trnp_pkg::CH_SPACE : trnp_pkg::CH_NEWLINE;
      end
      send_char(ch);
    end
  endtask

  // Check each taken result and drive the result-side stall pattern
  always @(posedge clk) begin : result_check
    word_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                 $time, status, value);
      end else begin
        want = pending_words.pop_front();
        check_field("status", want.status, status);
        check_field("value", want.value, value);
        check_field("line_end", want.line_end, line_end);
        check_field("word_length", want.word_length, word_length);
      end
    end
    rx_count++;
    if (rx_count % 16 == 0) rx_pattern = 16'($urandom);
    else rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    out_ready <= !rx_stall_on || rx_pattern[0];
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_special_words();
    test_radix_sweep();
    test_noise_bytes();
    drain_results();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/trnp_pkg.sv
design/trnp_ram.sv
design/trnp_ctrl.sv
design/trnp_dp.sv
design/token_reader_radix_number_parser.sv
verif/tb.sv
